/* rtl/clesq_pkg.sv */
// Shared types, codes and constants of the LCD expander byte sequencer.
package clesq_pkg;

  localparam int FUNC_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int BYTE_W  = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CMD  = 3'd0,
    FUNC_DATA = 3'd1,
    FUNC_DEC7 = 3'd2,
    FUNC_DEC2 = 3'd3,
    FUNC_STR  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_EMIT
  } front_state_t;

  // Low control nibble of the expander byte: backlight, enable, rw, rs.
  localparam logic [3:0]        CTL_CMD     = 4'hC;
  localparam logic [3:0]        CTL_DATA    = 4'hD;
  localparam logic [BYTE_W-1:0] STROBE_CMD  = 8'hF8;
  localparam logic [BYTE_W-1:0] STROBE_DATA = 8'hF9;
  localparam logic [BYTE_W-1:0] ASCII_SPACE = 8'h20;
  localparam logic [3:0]        ASCII_DIGIT = 4'h3;

  localparam logic [VALUE_W-1:0] DEC_LIMIT = 32'd10000000;
  localparam int NUM_DIGITS = 7;
  localparam int DIG_IDX_W  = 3;
  localparam int WORK_W     = 24;
  localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;
  localparam int RECIP_SHIFT = 35;
  localparam int QUOT_W      = WORK_W + 32 - RECIP_SHIFT;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One LCD byte waiting to be expanded into four expander bytes.
  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              is_data;
    logic              last;
  } lcd_ent_t;

endpackage

/* rtl/clesq_req_if.sv */
// Request channel: one LCD request per transaction.
interface clesq_req_if;
  import clesq_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   position;
  logic               run_start;

  modport source (output valid, func, value, position, run_start, input ready);
  modport sink   (input valid, func, value, position, run_start, output ready);
endinterface

/* rtl/clesq_rsp_if.sv */
// Result channel: one expander byte per transaction.
interface clesq_rsp_if;
  import clesq_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] expander_byte;
  logic              last;

  modport source (output valid, expander_byte, last, input ready);
  modport sink   (input valid, expander_byte, last, output ready);
endinterface

/* rtl/clesq_front.sv */
// Front end: accepts requests, converts decimals and lists the LCD bytes.
module clesq_front
  import clesq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  clesq_req_if.sink req,
  output lcd_ent_t  ent,
  output logic      ent_valid,
  input  logic      ent_ready
);

  front_state_t state, state_next;

  func_t                 fn;
  logic [BYTE_W-1:0]     value_lo;
  logic [POS_W-1:0]      pos;
  logic                  big;
  logic [DIG_IDX_W-1:0]  k;
  logic [DIG_IDX_W-1:0]  cnt;
  logic [WORK_W-1:0]     work;
  logic [3:0]            dig [NUM_DIGITS];

  logic                  accept;
  logic                  emit_last;
  logic [DIG_IDX_W-1:0]  j;
  logic [3:0]            dig_sel;
  logic [NUM_DIGITS-1:0] blank;
  logic                  zero_run;
  logic [BYTE_W-1:0]     str_ch;
  logic [WORK_W+31:0]    prod;
  logic [QUOT_W-1:0]     quot;
  logic [WORK_W-1:0]     rem_full;
  logic                  req_div;
  logic                  req_emit;

  assign accept = req.valid && req.ready;

  // Divide by ten through the reciprocal; exact for any 24-bit dividend.
  assign prod     = work * RECIP_TEN;
  assign quot     = prod[WORK_W+31:RECIP_SHIFT];
  assign rem_full = work - ({{(WORK_W-QUOT_W){1'b0}}, quot} << 3)
                         - ({{(WORK_W-QUOT_W){1'b0}}, quot} << 1);

  // Leading zeros become spaces, except the units digit.
  always_comb begin
    zero_run = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      zero_run = zero_run && (dig[i] == 4'd0);
      blank[i] = zero_run && (i < NUM_DIGITS - 1);
    end
  end

  assign j       = k - 1'b1;
  assign dig_sel = (j == DIG_IDX_W'(NUM_DIGITS)) ? 4'd0 : dig[j];
  assign str_ch  = (value_lo == '0) ? ASCII_SPACE : value_lo;

  always_comb begin
    case (fn)
      FUNC_CMD:  emit_last = 1'b1;
      FUNC_DATA: emit_last = 1'b1;
      FUNC_DEC7: emit_last = big || (k == DIG_IDX_W'(NUM_DIGITS));
      FUNC_DEC2: emit_last = (k == 3'd2);
      FUNC_STR:  emit_last = (k == 3'd1);
      default:   emit_last = 1'b1;
    endcase
  end

  always_comb begin
    ent.last    = emit_last;
    ent.is_data = 1'b1;
    ent.code    = value_lo;
    if ((k == '0) && (fn == FUNC_DEC7 || fn == FUNC_DEC2 || fn == FUNC_STR)) begin
      ent.code    = {1'b1, pos};
      ent.is_data = 1'b0;
    end else begin
      case (fn)
        FUNC_CMD: begin
          ent.code    = value_lo;
          ent.is_data = 1'b0;
        end
        FUNC_DATA: ent.code = value_lo;
        FUNC_STR:  ent.code = str_ch;
        FUNC_DEC7: ent.code = blank[j] ? ASCII_SPACE : {ASCII_DIGIT, dig_sel};
        FUNC_DEC2: ent.code = (k == 3'd1) ? {ASCII_DIGIT, dig[NUM_DIGITS-2]}
                                          : {ASCII_DIGIT, dig[NUM_DIGITS-1]};
        default:   ent.code = value_lo;
      endcase
    end
  end

  // Classification of the request being accepted.
  assign req_div  = (req.func == FUNC_DEC2) ||
                    ((req.func == FUNC_DEC7) && (req.value < DEC_LIMIT));
  assign req_emit = (req.func == FUNC_CMD) || (req.func == FUNC_DATA) ||
                    (req.func == FUNC_DEC7) || (req.func == FUNC_STR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ent_valid  = 1'b0;
    req.ready  = 1'b0;
    case (state)
      F_IDLE: begin
        req.ready = 1'b1;
      end
      F_DIV: begin
        if (cnt == DIG_IDX_W'(NUM_DIGITS - 1)) begin
          state_next = F_EMIT;
        end
      end
      F_EMIT: begin
        ent_valid = 1'b1;
        req.ready = emit_last && ent_ready;
        if (emit_last && ent_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
    if (accept) begin
      if (req_div) begin
        state_next = F_DIV;
      end else if (req_emit) begin
        state_next = F_EMIT;
      end else begin
        state_next = F_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fn       <= func_t'(req.func);
      value_lo <= req.value[BYTE_W-1:0];
      pos      <= req.position;
      big      <= (req.value >= DEC_LIMIT);
      work     <= (req.func == FUNC_DEC2) ? {{(WORK_W-BYTE_W){1'b0}}, req.value[BYTE_W-1:0]}
                                          : req.value[WORK_W-1:0];
      cnt      <= '0;
      k        <= ((req.func == FUNC_STR) && !req.run_start) ? 3'd1 : 3'd0;
    end else if (state == F_DIV) begin
      work   <= {{(WORK_W-QUOT_W){1'b0}}, quot};
      dig[0] <= rem_full[3:0];
      for (int i = 1; i < NUM_DIGITS; i++) begin
        dig[i] <= dig[i-1];
      end
      cnt <= cnt + 1'b1;
    end else if ((state == F_EMIT) && ent_ready) begin
      k <= k + 1'b1;
    end
  end

endmodule

/* rtl/clesq_queue.sv */
// Short queue of LCD bytes between the front and back ends.
module clesq_queue
  import clesq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  lcd_ent_t push_ent,
  input  logic     push_valid,
  output logic     push_ready,
  output lcd_ent_t pop_ent,
  output logic     pop_valid,
  input  logic     pop_ready
);

  lcd_ent_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_ent    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/clesq_back.sv */
// Back end: expands each LCD byte into four expander bytes.
module clesq_back
  import clesq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lcd_ent_t    ent,
  input  logic        ent_valid,
  output logic        ent_ready,
  clesq_rsp_if.source rsp
);

  lcd_ent_t          cur;
  logic              busy;
  logic [1:0]        phase;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  logic              slot_free;
  logic              step;
  logic              finishing;
  logic [3:0]        ctl;
  logic [BYTE_W-1:0] byte_next;

  assign slot_free = !out_valid || rsp.ready;
  assign step      = busy && slot_free;
  assign finishing = step && (phase == 2'd3);
  assign ent_ready = !busy || finishing;

  assign ctl = cur.is_data ? CTL_DATA : CTL_CMD;

  always_comb begin
    case (phase)
      2'd0:    byte_next = {cur.code[7:4], ctl};
      2'd1:    byte_next = cur.is_data ? STROBE_DATA : STROBE_CMD;
      2'd2:    byte_next = {cur.code[3:0], ctl};
      default: byte_next = STROBE_CMD;
    endcase
  end

  // The phase wraps back to zero on the last byte, so it is zero whenever idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
        phase     <= phase + 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (ent_valid && ent_ready) begin
        busy <= 1'b1;
      end else if (finishing) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ent_valid && ent_ready) begin
      cur <= ent;
    end
    if (step) begin
      out_byte <= byte_next;
      out_last <= cur.last && (phase == 2'd3);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.expander_byte = out_byte;
  assign rsp.last          = out_last;

endmodule

/* rtl/char_lcd_expander_byte_sequencer_top.sv */
// Top level of the LCD expander byte sequencer.
//
//   Channel  Role    Per transaction
//   req      sink    func, value, position, run_start: one LCD request
//   rsp      source  expander_byte, last: one byte for the port expander
//
// Each LCD byte leaves as four expander bytes, so a request gives 4, 8, 12 or 32
// expander bytes, or 4 for a seven-digit decimal that is too large; unused func
// codes are accepted and give no bytes. Decimal conversion runs in the front end,
// one digit per cycle, overlapped with the previous drain.
// Reset is synchronous and clears only control state; there is no clearing pass.
// A stall on rsp fills the queue and then holds req.
module char_lcd_expander_byte_sequencer_top
  import clesq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  clesq_req_if.sink   req,
  clesq_rsp_if.source rsp
);

  // The front end lists LCD bytes (address command, characters, digits).
  lcd_ent_t front_ent;
  logic     front_valid;
  logic     front_ready;

  // The queue decouples listing from the much slower byte expansion.
  lcd_ent_t back_ent;
  logic     back_valid;
  logic     back_ready;

  clesq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ent       (front_ent),
    .ent_valid (front_valid),
    .ent_ready (front_ready)
  );

  clesq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_ent   (front_ent),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_ent    (back_ent),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // The back end drives the result register that faces rsp.
  clesq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ent       (back_ent),
    .ent_valid (back_valid),
    .ent_ready (back_ready),
    .rsp       (rsp)
  );

endmodule

/* tb/tb_char_lcd_expander_byte_sequencer_top.sv */
// Testbench for the LCD expander byte sequencer: scoreboard class and top module.
`timescale 1ns / 1ps

import clesq_pkg::*;

// One LCD request as the testbench sees it.
typedef struct {
  logic [FUNC_W-1:0]  func;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   position;
  logic               run_start;
} lcd_req_t;

// One expected expander byte.
typedef struct {
  logic [BYTE_W-1:0] data;
  logic              last;
} exp_byte_t;

// Predicts the expander bytes of each request and checks the bytes that leave.
class expander_byte_board;
  localparam logic [BYTE_W-1:0] SET_ADDR = 8'h80;

  exp_byte_t exp_q[$];
  int        errors;
  int        bytes_checked;

  function new();
    errors        = 0;
    bytes_checked = 0;
  endfunction

  task report(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function int pending();
    return exp_q.size();
  endfunction

  // Four expander bytes per LCD byte: high nibble, strobe, low nibble, release.
  function void push_lcd(input logic [BYTE_W-1:0] code, input bit is_data);
    logic [3:0] ctl;
    exp_byte_t  e;
    ctl    = is_data ? CTL_DATA : CTL_CMD;
    e.last = 1'b0;
    e.data = {code[7:4], ctl};
    exp_q.push_back(e);
    e.data = is_data ? STROBE_DATA : STROBE_CMD;
    exp_q.push_back(e);
    e.data = {code[3:0], ctl};
    exp_q.push_back(e);
    e.data = STROBE_CMD;
    exp_q.push_back(e);
  endfunction

  function void note_request(input lcd_req_t r);
    int                first;
    int                i;
    int                ndig;
    logic [VALUE_W-1:0] v;
    logic [3:0]        digs[NUM_DIGITS];
    logic [BYTE_W-1:0] ch;
    logic [7:0]        two;
    first = exp_q.size();
    case (r.func)
      FUNC_CMD:  push_lcd(r.value[7:0], 1'b0);
      FUNC_DATA: push_lcd(r.value[7:0], 1'b1);
      FUNC_DEC7: begin
        push_lcd(SET_ADDR | BYTE_W'(r.position), 1'b0);
        if (r.value < DEC_LIMIT) begin
          v = r.value;
          for (i = NUM_DIGITS - 1; i >= 0; i--) begin
            digs[i] = 4'(v % 10);
            v       = v / 10;
          end
          // Count significant digits; zero still shows one digit.
          v    = r.value;
          ndig = 1;
          while (v >= 10) begin
            v = v / 10;
            ndig++;
          end
          for (i = 0; i < NUM_DIGITS; i++) begin
            ch = (i < NUM_DIGITS - ndig) ? ASCII_SPACE : {ASCII_DIGIT, digs[i]};
            push_lcd(ch, 1'b1);
          end
        end
      end
      FUNC_DEC2: begin
        two = 8'(r.value[7:0] % 100);
        push_lcd(SET_ADDR | BYTE_W'(r.position), 1'b0);
        push_lcd({ASCII_DIGIT, 4'(two / 10)}, 1'b1);
        push_lcd({ASCII_DIGIT, 4'(two % 10)}, 1'b1);
      end
      FUNC_STR: begin
        ch = (r.value[7:0] == 8'h00) ? ASCII_SPACE : r.value[7:0];
        if (r.run_start) push_lcd(SET_ADDR | BYTE_W'(r.position), 1'b0);
        push_lcd(ch, 1'b1);
      end
      default: ;
    endcase
    if (exp_q.size() > first) exp_q[exp_q.size() - 1].last = 1'b1;
  endfunction

  task check_byte(input logic [BYTE_W-1:0] data, input logic last);
    exp_byte_t e;
    bytes_checked++;
    if (exp_q.size() == 0) begin
      report($sformatf("byte 0x%02h last %0b with nothing expected", data, last));
    end else begin
      e = exp_q.pop_front();
      if (data !== e.data)
        report($sformatf("expander_byte 0x%02h, expected 0x%02h", data, e.data));
      if (last !== e.last)
        report($sformatf("last %0b, expected %0b (byte 0x%02h)", last, e.last, e.data));
    end
  endtask

  task finish_check();
    if (exp_q.size() != 0)
      report($sformatf("%0d expected bytes never arrived", exp_q.size()));
  endtask
endclass

module tb_char_lcd_expander_byte_sequencer_top;
  // The full-length decimal request is 32 bytes; with ready low about 30% of
  // the time and request gaps on top, a slow run still stays far below this.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 78;
  localparam int IDLE_PCT     = 30;

  // Func codes that the block accepts but turns into no bytes.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_MID   = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

  logic clk = 1'b0;
  logic rst;

  clesq_req_if req ();
  clesq_rsp_if rsp ();

  char_lcd_expander_byte_sequencer_top DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  expander_byte_board board;

  // While steady is set neither side idles, so the block runs at full rate.
  bit steady = 1'b0;
  int cycles = 0;
  int func_seen[8];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The result side stalls at random outside the steady stretch. Ready changes
  // on the falling edge, so it is stable at the sampling edge.
  always @(negedge clk) begin
    rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Every accepted result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) board.check_byte(rsp.expander_byte, rsp.last);
  end

  function automatic lcd_req_t make_req(input logic [FUNC_W-1:0] func,
                                        input logic [VALUE_W-1:0] value,
                                        input logic [POS_W-1:0] position,
                                        input logic run_start);
    lcd_req_t r;
    r.func      = func;
    r.value     = value;
    r.position  = position;
    r.run_start = run_start;
    return r;
  endfunction

  function automatic logic [FUNC_W-1:0] FUNC_SPARE(input logic [FUNC_W-1:0] lo,
                                                   input logic [FUNC_W-1:0] hi);
    return FUNC_W'($urandom_range(hi, lo));
  endfunction

  // Random requests lean toward the decimal and string modes, which are where
  // the block does most of its work. Decimal values mostly stay in range with
  // a random digit count so that every amount of space padding shows up.
  function automatic lcd_req_t rand_req();
    lcd_req_t r;
    int       pick;
    int       ndig;
    int       top;
    pick        = $urandom_range(99);
    r.value     = $urandom;
    r.position  = POS_W'($urandom_range(127));
    r.run_start = 1'($urandom_range(1));
    if (pick < 12) begin
      r.func = FUNC_CMD;
    end else if (pick < 24) begin
      r.func = FUNC_DATA;
    end else if (pick < 48) begin
      r.func = FUNC_DEC7;
      if ($urandom_range(9) != 0) begin
        ndig = $urandom_range(NUM_DIGITS, 1);
        top  = 1;
        repeat (ndig) top = top * 10;
        r.value = VALUE_W'($urandom_range(top - 1, 0));
      end
    end else if (pick < 66) begin
      r.func = FUNC_DEC2;
    end else if (pick < 92) begin
      r.func = FUNC_STR;
      // A zero character must turn into a space, so make it show up often.
      if ($urandom_range(7) == 0) r.value[7:0] = 8'h00;
    end else begin
      r.func = FUNC_SPARE(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST);
    end
    return r;
  endfunction

  // Offers one request and holds it until the block takes it. Gaps before the
  // request are random unless the steady stretch is on. Valid gets exactly one
  // assignment per falling edge, so a back-to-back request never dips low.
  task automatic send_request(input lcd_req_t r);
    while (!steady && ($urandom_range(99) < IDLE_PCT)) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.func      <= r.func;
    req.value     <= r.value;
    req.position  <= r.position;
    req.run_start <= r.run_start;
    do @(posedge clk); while (!req.ready);
    board.note_request(r);
    func_seen[r.func]++;
    @(negedge clk);
  endtask

  lcd_req_t directed[$];

  initial begin
    int k;
    board         = new();
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.func      = '0;
    req.value     = '0;
    req.position  = '0;
    req.run_start = 1'b0;
    rsp.ready     = 1'b0;
    for (k = 0; k < 8; k++) func_seen[k] = 0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: byte extremes, every func, the decimal edge values (zero,
    // one digit, all seven digits, the first value that is too large and the
    // largest word), two-digit wrap above 99, the zero character, a string run
    // start at both address extremes, and each unused func code.
    directed.push_back(make_req(FUNC_CMD,  32'h0000_0000, 7'd0,   1'b0));
    directed.push_back(make_req(FUNC_CMD,  32'hFFFF_FFFF, 7'd127, 1'b1));
    directed.push_back(make_req(FUNC_DATA, 32'h0000_0000, 7'd0,   1'b0));
    directed.push_back(make_req(FUNC_DATA, 32'hFFFF_FF5A, 7'd64,  1'b1));
    directed.push_back(make_req(FUNC_DEC7, 32'd0,         7'd0,   1'b0));
    directed.push_back(make_req(FUNC_DEC7, 32'd7,         7'd127, 1'b1));
    directed.push_back(make_req(FUNC_DEC7, 32'd10,        7'd5,   1'b0));
    directed.push_back(make_req(FUNC_DEC7, 32'd1234567,   7'd40,  1'b0));
    directed.push_back(make_req(FUNC_DEC7, 32'd9999999,   7'd0,   1'b0));
    directed.push_back(make_req(FUNC_DEC7, 32'd10000000,  7'd127, 1'b0));
    directed.push_back(make_req(FUNC_DEC7, 32'hFFFF_FFFF, 7'd85,  1'b1));
    directed.push_back(make_req(FUNC_DEC2, 32'd0,         7'd0,   1'b0));
    directed.push_back(make_req(FUNC_DEC2, 32'd99,        7'd127, 1'b0));
    directed.push_back(make_req(FUNC_DEC2, 32'd100,       7'd20,  1'b1));
    directed.push_back(make_req(FUNC_DEC2, 32'hFFFF_FFFF, 7'd84,  1'b0));
    directed.push_back(make_req(FUNC_STR,  32'h0000_0000, 7'd127, 1'b1));
    directed.push_back(make_req(FUNC_STR,  32'h0000_0041, 7'd3,   1'b0));
    directed.push_back(make_req(FUNC_STR,  32'hFFFF_FF00, 7'd10,  1'b0));
    directed.push_back(make_req(FUNC_STR,  32'h0000_00FF, 7'd0,   1'b1));
    directed.push_back(make_req(FUNC_UNUSED_FIRST, 32'hFFFF_FFFF, 7'd127, 1'b1));
    directed.push_back(make_req(FUNC_UNUSED_MID,   32'h0000_0000, 7'd0,   1'b0));
    directed.push_back(make_req(FUNC_UNUSED_LAST,  32'hA5A5_5A5A, 7'd42,  1'b1));
    foreach (directed[i]) send_request(directed[i]);

    // Random part, with a stretch in the middle where neither side idles.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      steady = (k >= 40) && (k < 75);
      send_request(rand_req());
    end
    steady = 1'b0;
    req.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.finish_check();

    $display("Covered %0d requests: command %0d, data %0d, decimal7 %0d, decimal2 %0d,",
             func_seen[FUNC_CMD] + func_seen[FUNC_DATA] + func_seen[FUNC_DEC7] +
             func_seen[FUNC_DEC2] + func_seen[FUNC_STR] + func_seen[FUNC_UNUSED_FIRST] +
             func_seen[FUNC_UNUSED_MID] + func_seen[FUNC_UNUSED_LAST],
             func_seen[FUNC_CMD], func_seen[FUNC_DATA], func_seen[FUNC_DEC7],
             func_seen[FUNC_DEC2]);
    $display("  string %0d, unused codes %0d; %0d expander bytes checked, %0d mismatches",
             func_seen[FUNC_STR],
             func_seen[FUNC_UNUSED_FIRST] + func_seen[FUNC_UNUSED_MID] +
             func_seen[FUNC_UNUSED_LAST],
             board.bytes_checked, board.errors);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* char_lcd_expander_byte_sequencer_top.f */
rtl/clesq_pkg.sv
rtl/clesq_req_if.sv
rtl/clesq_rsp_if.sv
rtl/clesq_front.sv
rtl/clesq_queue.sv
rtl/clesq_back.sv
rtl/char_lcd_expander_byte_sequencer_top.sv
tb/tb_char_lcd_expander_byte_sequencer_top.sv
